// File: rtl/dos_pkg.sv
// Shared types and constants for the door opener controller.
package dos_pkg;

   // Item kinds carried in tuser
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_SENSOR = 2'd1;
   localparam logic [1:0] OP_SWITCH = 2'd2;
   localparam logic [1:0] OP_REMOTE = 2'd3;

   // Remote request codes
   localparam logic [2:0] REQ_LIGHT_ON  = 3'd0;
   localparam logic [2:0] REQ_LIGHT_OFF = 3'd1;
   localparam logic [2:0] REQ_CLOSE     = 3'd2;
   localparam logic [2:0] REQ_OPEN      = 3'd3;
   localparam logic [2:0] REQ_STOP      = 3'd4;

   // Door status codes as reported on the result channel
   localparam logic [2:0] STATUS_OPEN    = 3'd0;
   localparam logic [2:0] STATUS_OPENING = 3'd1;
   localparam logic [2:0] STATUS_CLOSED  = 3'd2;
   localparam logic [2:0] STATUS_CLOSING = 3'd3;
   localparam logic [2:0] STATUS_STOPPED = 3'd4;
   localparam logic [2:0] STATUS_UNKNOWN = 3'd5;
   localparam logic [2:0] STATUS_BAD     = 3'd6;

   // Travel direction codes
   localparam logic [1:0] DIR_UP   = 2'd0;
   localparam logic [1:0] DIR_DOWN = 2'd1;
   localparam logic [1:0] DIR_NONE = 2'd2;

   // Command output bits: open, close, stop, light
   localparam logic [3:0] DRV_NONE  = 4'b0000;
   localparam logic [3:0] DRV_OPEN  = 4'b0001;
   localparam logic [3:0] DRV_CLOSE = 4'b0010;
   localparam logic [3:0] DRV_STOP  = 4'b0100;
   localparam logic [3:0] DRV_LIGHT = 4'b1000;

   // Pulse length after reset: 2000 ticks per unit times 10
   localparam logic [15:0] PULSE_RESET = 16'(2000 * 10);

   // Door state, one-hot
   typedef enum logic [6:0] {
      DOOR_OPEN    = 7'b0000001,
      DOOR_OPENING = 7'b0000010,
      DOOR_CLOSED  = 7'b0000100,
      DOOR_CLOSING = 7'b0001000,
      DOOR_STOPPED = 7'b0010000,
      DOOR_UNKNOWN = 7'b0100000,
      DOOR_BAD     = 7'b1000000
   } door_state_type;

   // Map the one-hot door state to its status code
   function automatic logic [2:0] door_status_code(door_state_type st);
      logic [2:0] code;
      case (st)
         DOOR_OPEN:    code = STATUS_OPEN;
         DOOR_OPENING: code = STATUS_OPENING;
         DOOR_CLOSED:  code = STATUS_CLOSED;
         DOOR_CLOSING: code = STATUS_CLOSING;
         DOOR_STOPPED: code = STATUS_STOPPED;
         DOOR_BAD:     code = STATUS_BAD;
         default:      code = STATUS_UNKNOWN;
      endcase
      return code;
   endfunction

endpackage

// File: rtl/door_opener_state_machine.sv
// Door opener controller: door state tracking and timed command pulses.
// A result appears on the rsp channel in the cycle after its req transfer.
// Throughput: one item per cycle; the state update and the result register are loaded
//   in the same cycle, and the next item is taken in the cycle the waiting result is
//   taken, so a stalled result holds off the input.
// Reset (synchronous, active high): door unknown, direction none, all outputs
//   off, no pulse running, pulse length 20000 ticks, result register empty.
module door_opener_state_machine (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,    // pulse_ticks
   // item input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,      // open_sensed, closed_sensed, request_code[2:0], zero pad
   input  logic [1:0]  req_tuser,      // opcode[1:0]
   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata       // door_status[2:0], last_direction[1:0], open_drive,
                                       // close_drive, stop_drive, light_drive, zero pad
);

   logic [15:0]             pulse_ticks_ff;
   dos_pkg::door_state_type door_ff, door_in;
   logic [1:0]              dir_ff, dir_in;
   logic [15:0]             left_ff, left_in;
   logic [3:0]              drive_ff, drive_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [15:0]             rsp_data_ff, rsp_data_in;

   logic                    req_xfer;
   logic                    open_sensed;
   logic                    closed_sensed;
   logic [2:0]              request_code;
   logic [15:0]             pulse_len;
   logic                    start;
   logic [3:0]              start_bits;

   assign open_sensed   = req_tdata[0];
   assign closed_sensed = req_tdata[1];
   assign request_code  = req_tdata[4:2];

   // Take a new item when the result slot is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   // Zero pulse length acts as one
   assign pulse_len = (pulse_ticks_ff == 16'd0) ? 16'd1 : pulse_ticks_ff;

   // Pick the command pulse, if any, that this item starts
   always_comb begin
      start      = 1'b0;
      start_bits = dos_pkg::DRV_NONE;
      case (req_tuser)
         dos_pkg::OP_SWITCH: begin
            case (door_ff)
               dos_pkg::DOOR_CLOSED: begin
                  start      = 1'b1;
                  start_bits = dos_pkg::DRV_OPEN;
               end
               dos_pkg::DOOR_OPEN: begin
                  start      = 1'b1;
                  start_bits = dos_pkg::DRV_CLOSE;
               end
               dos_pkg::DOOR_OPENING, dos_pkg::DOOR_CLOSING: begin
                  start      = 1'b1;
                  start_bits = dos_pkg::DRV_STOP;
               end
               dos_pkg::DOOR_STOPPED: begin
                  if (dir_ff == dos_pkg::DIR_DOWN) begin
                     start      = 1'b1;
                     start_bits = dos_pkg::DRV_OPEN;
                  end else if (dir_ff == dos_pkg::DIR_UP) begin
                     start      = 1'b1;
                     start_bits = dos_pkg::DRV_CLOSE;
                  end
               end
               default: begin
               end
            endcase
         end
         dos_pkg::OP_REMOTE: begin
            case (request_code)
               dos_pkg::REQ_LIGHT_ON, dos_pkg::REQ_LIGHT_OFF: begin
                  start      = 1'b1;
                  start_bits = dos_pkg::DRV_LIGHT;
               end
               dos_pkg::REQ_CLOSE: begin
                  start      = 1'b1;
                  start_bits = dos_pkg::DRV_CLOSE;
               end
               dos_pkg::REQ_OPEN: begin
                  start      = 1'b1;
                  start_bits = dos_pkg::DRV_OPEN;
               end
               dos_pkg::REQ_STOP: begin
                  start      = 1'b1;
                  start_bits = dos_pkg::DRV_STOP;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // Next door state, direction, pulse counter and outputs
   always_comb begin
      door_in  = door_ff;
      dir_in   = dir_ff;
      left_in  = left_ff;
      drive_in = drive_ff;
      if (req_xfer) begin
         case (req_tuser)
            dos_pkg::OP_TICK: begin
               if (left_ff != 16'd0) begin
                  left_in = left_ff - 16'd1;
                  if (left_ff == 16'd1) begin
                     drive_in = dos_pkg::DRV_NONE;
                  end
               end
            end
            dos_pkg::OP_SENSOR: begin
               if (open_sensed && closed_sensed) begin
                  door_in = dos_pkg::DOOR_BAD;
                  dir_in  = dos_pkg::DIR_NONE;
               end else if (open_sensed) begin
                  door_in = dos_pkg::DOOR_OPEN;
                  dir_in  = dos_pkg::DIR_NONE;
               end else if (closed_sensed) begin
                  door_in = dos_pkg::DOOR_CLOSED;
                  dir_in  = dos_pkg::DIR_NONE;
               end else if (door_ff == dos_pkg::DOOR_OPEN) begin
                  door_in = dos_pkg::DOOR_CLOSING;
                  dir_in  = dos_pkg::DIR_DOWN;
               end else if (door_ff == dos_pkg::DOOR_CLOSED) begin
                  door_in = dos_pkg::DOOR_OPENING;
                  dir_in  = dos_pkg::DIR_UP;
               end else if (door_ff == dos_pkg::DOOR_BAD) begin
                  door_in = dos_pkg::DOOR_UNKNOWN;
                  dir_in  = dos_pkg::DIR_NONE;
               end
            end
            default: begin
               if (start) begin
                  left_in  = pulse_len;
                  drive_in = start_bits;
               end
               if (req_tuser == dos_pkg::OP_SWITCH &&
                   (door_ff == dos_pkg::DOOR_OPENING ||
                    door_ff == dos_pkg::DOOR_CLOSING)) begin
                  door_in = dos_pkg::DOOR_STOPPED;
               end
            end
         endcase
      end
   end

   // Result slot: load on a req transfer, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, drive_in[3], drive_in[2], drive_in[1], drive_in[0],
                         dir_in, dos_pkg::door_status_code(door_in)};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ticks_ff <= dos_pkg::PULSE_RESET;
         door_ff        <= dos_pkg::DOOR_UNKNOWN;
         dir_ff         <= dos_pkg::DIR_NONE;
         left_ff        <= 16'd0;
         drive_ff       <= dos_pkg::DRV_NONE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pulse_ticks_ff <= csr_wr_data;
         end
         door_ff      <= door_in;
         dir_ff       <= dir_in;
         left_ff      <= left_in;
         drive_ff     <= drive_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
